// ===== rtl/ptem_pkg.sv =====
// Shared types and constants for the periodic threshold event monitor.
package ptem_pkg;

    localparam int NUM_SLOTS   = 6;
    localparam int SLOT_CAP    = 6;
    localparam int PERIOD_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int SAMPLE_BITS = 32;
    localparam int WORD_BITS   = 56;
    localparam int DATA_BITS   = 64;
    localparam int REG_IDX_BITS = $clog2(SLOT_CAP + 1);
    localparam int ADDR_BITS   = REG_IDX_BITS + 3;
    localparam int SLOT_IDX_BITS = $clog2(SLOT_CAP);

    localparam logic [COUNT_BITS-1:0] PERIOD_MASK =
        (PERIOD_BITS >= COUNT_BITS) ? {COUNT_BITS{1'b1}}
                                    : COUNT_BITS'((64'd1 << PERIOD_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] DEFAULT_MAX_DELAY = 16'd1000;

    localparam logic [REG_IDX_BITS-1:0] REG_MAX_DELAY = REG_IDX_BITS'(SLOT_CAP);

    typedef enum logic [1:0] {
        OP_LT  = 2'd0,
        OP_GT  = 2'd1,
        OP_EQ  = 2'd2,
        OP_BAD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_INFO     = 2'd1,
        ACT_RESET    = 2'd2,
        ACT_POWEROFF = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CH_TEMP = 2'd0,
        CH_PH   = 2'd1,
        CH_PPM  = 2'd2,
        CH_NONE = 2'd3
    } channel_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] threshold;
        logic                          active;
        channel_t                      channel;
        action_t                       action;
        op_t                           op;
        logic [COUNT_BITS-1:0]         period;
    } slot_cfg_t;

    typedef struct packed {
        logic [SLOT_CAP-1:0]   en;
        logic [COUNT_BITS-1:0] period;
    } reload_t;

endpackage

// ===== rtl/ptem_if.sv =====
// Valid/ready channel interfaces for sample and result words.
interface ptem_sample_if
    import ptem_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] temp_sample;
    logic signed [SAMPLE_BITS-1:0] ph_sample;
    logic signed [SAMPLE_BITS-1:0] ppm_sample;

    modport source (output valid, temp_sample, ph_sample, ppm_sample, input ready);
    modport sink   (input valid, temp_sample, ph_sample, ppm_sample, output ready);
endinterface

interface ptem_result_if
    import ptem_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] next_delay;
    logic [SLOT_CAP-1:0]   fired_mask;
    logic                  info_request;
    logic                  reset_request;
    logic                  poweroff_request;

    modport source (output valid, next_delay, fired_mask, info_request, reset_request,
                    poweroff_request, input ready);
    modport sink   (input valid, next_delay, fired_mask, info_request, reset_request,
                    poweroff_request, output ready);
endinterface

// ===== rtl/ptem_cfg_regs.sv =====
// APB register file holding the slot words and max_delay.
module ptem_cfg_regs
    import ptem_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    output slot_cfg_t             slot_cfg [SLOT_CAP],
    output logic [COUNT_BITS-1:0] max_delay,
    output reload_t               reload
);

    logic [WORD_BITS-1:0]    slot_word_reg [SLOT_CAP];
    logic [COUNT_BITS-1:0]   max_delay_reg;
    logic                    wr;
    logic [REG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_BITS-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_CAP; i++)
            begin
                slot_word_reg[i] <= '0;
            end
            max_delay_reg <= DEFAULT_MAX_DELAY;
        end
        else if (wr)
        begin
            for (int i = 0; i < SLOT_CAP; i++)
            begin
                if (idx == REG_IDX_BITS'(i))
                begin
                    slot_word_reg[i] <= pwdata[WORD_BITS-1:0];
                end
            end
            if (idx == REG_MAX_DELAY)
            begin
                max_delay_reg <= pwdata[COUNT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        priority if (idx < REG_MAX_DELAY)
        begin
            prdata = DATA_BITS'(slot_word_reg[idx[SLOT_IDX_BITS-1:0]]);
        end
        else if (idx == REG_MAX_DELAY)
        begin
            prdata = DATA_BITS'(max_delay_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOT_CAP; i++)
        begin
            slot_cfg[i].period    = slot_word_reg[i][15:0] & PERIOD_MASK;
            slot_cfg[i].op        = op_t'(slot_word_reg[i][17:16]);
            slot_cfg[i].action    = action_t'(slot_word_reg[i][19:18]);
            slot_cfg[i].channel   = channel_t'(slot_word_reg[i][21:20]);
            // slots past NUM_SLOTS keep their word but stay dormant
            slot_cfg[i].active    = slot_word_reg[i][22] && (i < NUM_SLOTS);
            slot_cfg[i].threshold = signed'(slot_word_reg[i][55:24]);
            reload.en[i]          = wr && (idx == REG_IDX_BITS'(i));
        end
        reload.period = pwdata[15:0] & PERIOD_MASK;
    end

    assign max_delay = max_delay_reg;

endmodule

// ===== rtl/ptem_slot_eval.sv =====
// One slot's countdown step and threshold compare for a check pass.
module ptem_slot_eval
    import ptem_pkg::*;
(
    input  slot_cfg_t                     cfg,
    input  logic [COUNT_BITS-1:0]         countdown,
    input  logic [COUNT_BITS-1:0]         elapsed,
    input  logic signed [SAMPLE_BITS-1:0] temp_sample,
    input  logic signed [SAMPLE_BITS-1:0] ph_sample,
    input  logic signed [SAMPLE_BITS-1:0] ppm_sample,
    output logic [COUNT_BITS-1:0]         count_next,
    output logic                          fired,
    output logic                          counted
);

    logic                          due;
    logic                          ch_ok;
    logic                          hit;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [COUNT_BITS-1:0]         dec;

    // saturating subtract of the elapsed time
    assign dec = (countdown > elapsed) ? countdown - elapsed : '0;
    assign due = (dec == '0);

    always_comb
    begin
        ch_ok = 1'b1;
        unique case (cfg.channel)
            CH_TEMP: sample = temp_sample;
            CH_PH:   sample = ph_sample;
            CH_PPM:  sample = ppm_sample;
            default:
            begin
                sample = '0;
                ch_ok  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cfg.op)
            OP_LT:   hit = sample < cfg.threshold;
            OP_GT:   hit = sample > cfg.threshold;
            OP_EQ:   hit = sample == cfg.threshold;
            default: hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!cfg.active)
        begin
            count_next = countdown;
        end
        else if (due)
        begin
            count_next = cfg.period;
        end
        else
        begin
            count_next = dec;
        end
    end

    assign fired   = cfg.active && due && (cfg.period != '0) && ch_ok && hit;
    assign counted = cfg.active && (count_next != '0);

endmodule

// ===== rtl/periodic_threshold_event_monitor.sv =====
// Top level: input register, per-slot update, minimum tree and result register.
//
// Accepts one sample word per clock and returns one result word per sample.
// A sample word accepted by the handshake is loaded into the input register,
// and its pass is loaded into the result register once the result side has room;
// the result word is valid from then on. All six slots update in parallel and
// the next-delay minimum is a pairwise compare tree between the two registers,
// so the sustained rate is one word per cycle as long as the result side takes
// words. Slot words sit at byte address 8*i, max_delay at 0x30, 64-bit data;
// writing a slot word reloads its countdown with the new period. Write
// configuration only while no word is in flight.
module periodic_threshold_event_monitor
    import ptem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    ptem_sample_if.sink          sample_in,
    ptem_result_if.source        result_out
);

    slot_cfg_t             slot_cfg [SLOT_CAP];
    logic [COUNT_BITS-1:0] max_delay;
    reload_t               reload;

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] temp_reg;
    logic signed [SAMPLE_BITS-1:0] ph_reg;
    logic signed [SAMPLE_BITS-1:0] ppm_reg;

    logic [COUNT_BITS-1:0] countdown_reg [SLOT_CAP];
    logic [COUNT_BITS-1:0] countdown_next [SLOT_CAP];
    logic [COUNT_BITS-1:0] elapsed_reg;
    logic [SLOT_CAP-1:0]   fired;
    logic [SLOT_CAP-1:0]   counted;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] delay_reg;
    logic [SLOT_CAP-1:0]   fired_reg;
    logic                  info_reg;
    logic                  reset_reg;
    logic                  poff_reg;

    logic [COUNT_BITS-1:0] limit;
    logic [COUNT_BITS-1:0] min_tree [SLOT_CAP];
    logic [COUNT_BITS-1:0] best_next;
    logic                  info_next;
    logic                  reset_next;
    logic                  poff_next;
    logic                  adv;

    ptem_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .slot_cfg  (slot_cfg),
        .max_delay (max_delay),
        .reload    (reload)
    );

    for (genvar g = 0; g < SLOT_CAP; g++)
    begin : g_slot
        ptem_slot_eval u_eval (
            .cfg         (slot_cfg[g]),
            .countdown   (countdown_reg[g]),
            .elapsed     (elapsed_reg),
            .temp_sample (temp_reg),
            .ph_sample   (ph_reg),
            .ppm_sample  (ppm_reg),
            .count_next  (countdown_next[g]),
            .fired       (fired[g]),
            .counted     (counted[g])
        );
    end

    assign adv             = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !s1_valid_reg || adv;

    assign limit = (max_delay == '0) ? COUNT_BITS'(1) : max_delay;

    always_comb
    begin
        info_next  = 1'b0;
        reset_next = 1'b0;
        poff_next  = 1'b0;
        // each leaf is already clipped to the limit
        for (int i = 0; i < SLOT_CAP; i++)
        begin
            if (counted[i] && (countdown_next[i] < limit))
            begin
                min_tree[i] = countdown_next[i];
            end
            else
            begin
                min_tree[i] = limit;
            end
        end
        // pairwise reduction into entry 0
        for (int s = 1; s < SLOT_CAP; s = s * 2)
        begin
            for (int i = 0; i + s < SLOT_CAP; i = i + 2 * s)
            begin
                if (min_tree[i + s] < min_tree[i])
                begin
                    min_tree[i] = min_tree[i + s];
                end
            end
        end
        best_next = min_tree[0];
        for (int i = 0; i < SLOT_CAP; i++)
        begin
            if (fired[i])
            begin
                unique case (slot_cfg[i].action)
                    ACT_INFO:     info_next  = 1'b1;
                    ACT_RESET:    reset_next = 1'b1;
                    ACT_POWEROFF: poff_next  = 1'b1;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            elapsed_reg   <= '0;
            for (int i = 0; i < SLOT_CAP; i++)
            begin
                countdown_reg[i] <= '0;
            end
        end
        else
        begin
            if (sample_in.valid && sample_in.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                elapsed_reg <= best_next;
            end

            for (int i = 0; i < SLOT_CAP; i++)
            begin
                if (reload.en[i])
                begin
                    countdown_reg[i] <= reload.period;
                end
                else if (adv)
                begin
                    countdown_reg[i] <= countdown_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            temp_reg <= sample_in.temp_sample;
            ph_reg   <= sample_in.ph_sample;
            ppm_reg  <= sample_in.ppm_sample;
        end
        if (adv)
        begin
            delay_reg <= best_next;
            fired_reg <= fired;
            info_reg  <= info_next;
            reset_reg <= reset_next;
            poff_reg  <= poff_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.next_delay       = delay_reg;
    assign result_out.fired_mask       = fired_reg;
    assign result_out.info_request     = info_reg;
    assign result_out.reset_request    = reset_reg;
    assign result_out.poweroff_request = poff_reg;

    a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> result_out.next_delay != '0)
        else $error("next_delay is zero");

    a_delay_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> best_next <= limit)
        else $error("next_delay above max_delay");

    a_request_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && (result_out.info_request || result_out.reset_request
                             || result_out.poweroff_request)
        |-> result_out.fired_mask != '0)
        else $error("request raised without a fired slot");

    a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> result_out.valid && elapsed_reg == result_out.next_delay)
        else $error("pass did not reach the result register");

endmodule
